FILE: rtl/core/bstp_pkg.sv
// ----------------------------------------------------------------------------
// bstp_pkg
// Shared types and constants of the binary stroke thinning pass.
// ----------------------------------------------------------------------------
package bstp_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Configuration register file.
  localparam int          CFG_W        = 11;
  localparam logic [10:0] CFG_SIZE_RST = 11'd1024;
  localparam int          REG_IDX_W    = 1;
  localparam logic [0:0]  REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0]  REG_IMAGE_HEIGHT = 1'b1;

  // Bit positions in a line memory word.
  localparam int LINE_WORD_W = 2;
  localparam int RAW_BIT     = 0;
  localparam int DONE_BIT    = 1;

  // Output queue.
  localparam int OFIFO_AW    = 2;
  localparam int OFIFO_DEPTH = 1 << OFIFO_AW;

  // Control flags carried from the accept stage to the update stage.
  typedef struct packed {
    logic row_zero;  // first row of a frame, no thinning result
    logic flush;     // emit the previous frame's last row instead
    logic thin_ok;   // interior pixel with a valid upper row
    logic last_col;
    logic pix;
  } s1_ctrl_t;

  typedef struct packed {
    logic frame_end;
    logic pixel;
  } out_item_t;

endpackage

FILE: rtl/core/bstp_ram.sv
// ----------------------------------------------------------------------------
// bstp_ram
// Generic memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bstp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/core/binary_stroke_thinning_pass.sv
// ----------------------------------------------------------------------------
// binary_stroke_thinning_pass
// One in-place 3x3 thinning pass over a raster-order binary pixel stream.
// ----------------------------------------------------------------------------
// The block takes one pixel per cycle while its output queue has room and
// returns each thinned pixel one image row later; the last row of a frame comes
// out while the first row of the next frame is fed in, with frame_end on its
// final pixel. The accept cycle issues both reads of the single line memory
// (holding the original and thinned value of every column), and the next cycle
// computes the result, writes it back and places it in a four-entry output
// queue. The throughput of one pixel per cycle is set by that memory, which
// serves two reads and one write each cycle. The line memory needs no clearing
// after reset, so the block is ready at once. The user must write image width
// and height over the APB port only while the block is idle; it is not enforced.
module binary_stroke_thinning_pass #(
  parameter int MAX_WIDTH  = bstp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bstp_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_pixel_out,
  output logic        out_frame_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RB = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int XW = (WW > bstp_pkg::CFG_W) ? WW : bstp_pkg::CFG_W;
  localparam int YW = (HW > bstp_pkg::CFG_W) ? HW : bstp_pkg::CFG_W;
  localparam int LW = bstp_pkg::LINE_WORD_W;
  localparam int QW = bstp_pkg::OFIFO_AW;

  // Configuration registers.
  logic [bstp_pkg::CFG_W-1:0]     image_width_r, image_height_r;
  logic [bstp_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= bstp_pkg::CFG_SIZE_RST;
      image_height_r <= bstp_pkg::CFG_SIZE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        bstp_pkg::REG_IMAGE_WIDTH:  image_width_r  <= pwdata[bstp_pkg::CFG_W-1:0];
        bstp_pkg::REG_IMAGE_HEIGHT: image_height_r <= pwdata[bstp_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bstp_pkg::REG_IMAGE_WIDTH:  prdata = {{(32 - bstp_pkg::CFG_W){1'b0}}, image_width_r};
      bstp_pkg::REG_IMAGE_HEIGHT: prdata = {{(32 - bstp_pkg::CFG_W){1'b0}}, image_height_r};
      default:                    prdata = '0;
    endcase
  end

  // Effective image size, clamped to 2 .. MAX.
  logic [XW-1:0] wx;
  logic [YW-1:0] hx;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    wx = XW'(image_width_r);
    hx = YW'(image_height_r);
    if (wx < XW'(2)) begin
      w_eff = WW'(2);
    end else if (wx > XW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(wx);
    end
    if (hx < YW'(2)) begin
      h_eff = HW'(2);
    end else if (hx > YW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(hx);
    end
  end

  // Accept stage: position tracking and memory reads.
  logic [CB-1:0]       col_r, col_nxt, c_eff, rd_b_addr;
  logic [RB-1:0]       row_r, row_nxt, r_eff;
  logic                flush_pending_r, flush_pending_nxt;
  logic                col_wrap, last_col, last_row, accept;
  logic [HW-1:0]       r_tmp, r_inc;
  logic [WW-1:0]       c_inc;
  bstp_pkg::s1_ctrl_t  ctrl_nxt;

  assign accept = in_valid && in_ready;

  always_comb begin
    col_wrap  = WW'(col_r) >= w_eff;
    c_eff     = col_wrap ? '0 : col_r;
    r_tmp     = HW'(row_r) + HW'(col_wrap);
    r_eff     = (r_tmp >= h_eff) ? '0 : RB'(r_tmp);
    c_inc     = WW'(c_eff) + WW'(1);
    r_inc     = HW'(r_eff) + HW'(1);
    last_col  = c_inc >= w_eff;
    last_row  = r_inc >= h_eff;
    rd_b_addr = CB'(c_inc);

    col_nxt           = col_r;
    row_nxt           = row_r;
    flush_pending_nxt = flush_pending_r;
    if (accept) begin
      col_nxt = last_col ? '0 : CB'(c_inc);
      row_nxt = r_eff;
      if (r_eff == '0 && flush_pending_r && last_col) begin
        flush_pending_nxt = 1'b0;
      end
      if (last_col) begin
        row_nxt = last_row ? '0 : RB'(r_inc);
        if (last_row) begin
          flush_pending_nxt = 1'b1;
        end
      end
    end

    ctrl_nxt.row_zero = (r_eff == '0);
    ctrl_nxt.flush    = (r_eff == '0) && flush_pending_r;
    ctrl_nxt.thin_ok  = (r_eff > RB'(1)) && (c_eff != '0) && !last_col;
    ctrl_nxt.last_col = last_col;
    ctrl_nxt.pix      = in_pixel_in;
  end

  // Update stage: thinning decision and write back.
  logic                s1_valid_r;
  logic [CB-1:0]       s1_col_r;
  bstp_pkg::s1_ctrl_t  s1_ctrl_r;
  logic                left_done_r;
  logic                fwd_a_r, fwd_b_r;
  logic [LW-1:0]       fwd_word_r;
  logic [LW-1:0]       ram_a, ram_b, a_word, wr_word;
  logic                raw_c, up, rt, lf, dn, v, adj, push;
  logic [2:0]          cnt;
  bstp_pkg::out_item_t push_item;

  bstp_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .we      (s1_valid_r),
    .waddr   (s1_col_r),
    .wdata   (wr_word),
    .raddr_a (c_eff),
    .rdata_a (ram_a),
    .raddr_b (rd_b_addr),
    .rdata_b (ram_b)
  );

  always_comb begin
    // A write that lands on the same edge as the read is taken from the bypass.
    a_word = fwd_a_r ? fwd_word_r : ram_a;
    rt     = fwd_b_r ? fwd_word_r[bstp_pkg::RAW_BIT] : ram_b[bstp_pkg::RAW_BIT];
    raw_c  = a_word[bstp_pkg::RAW_BIT];
    up     = a_word[bstp_pkg::DONE_BIT];
    lf     = left_done_r;
    dn     = s1_ctrl_r.pix;
    cnt    = 3'(rt) + 3'(up) + 3'(lf) + 3'(dn);
    adj    = (rt && up) || (up && lf) || (lf && dn) || (dn && rt);
    v      = raw_c;
    if (raw_c && s1_ctrl_r.thin_ok && (cnt == 3'd3 || (cnt == 3'd2 && adj))) begin
      v = 1'b0;
    end

    wr_word = '0;
    wr_word[bstp_pkg::RAW_BIT]  = s1_ctrl_r.pix;
    wr_word[bstp_pkg::DONE_BIT] = s1_ctrl_r.row_zero ? up : v;

    push = s1_valid_r && (!s1_ctrl_r.row_zero || s1_ctrl_r.flush);
    if (s1_ctrl_r.row_zero) begin
      push_item.pixel     = raw_c;
      push_item.frame_end = s1_ctrl_r.last_col;
    end else begin
      push_item.pixel     = v;
      push_item.frame_end = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r           <= '0;
      row_r           <= '0;
      flush_pending_r <= 1'b0;
      s1_valid_r      <= 1'b0;
      left_done_r     <= 1'b0;
      fwd_a_r         <= 1'b0;
      fwd_b_r         <= 1'b0;
    end else begin
      col_r           <= col_nxt;
      row_r           <= row_nxt;
      flush_pending_r <= flush_pending_nxt;
      s1_valid_r      <= accept;
      fwd_a_r         <= s1_valid_r && (s1_col_r == c_eff);
      fwd_b_r         <= s1_valid_r && (s1_col_r == rd_b_addr);
      if (s1_valid_r && !s1_ctrl_r.row_zero) begin
        left_done_r <= v;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_word_r <= wr_word;
    if (accept) begin
      s1_col_r  <= c_eff;
      s1_ctrl_r <= ctrl_nxt;
    end
  end

  // Output queue; it always has room for the result still in the update stage.
  bstp_pkg::out_item_t ofifo_r [bstp_pkg::OFIFO_DEPTH];
  logic [QW-1:0]       wr_ptr_r, rd_ptr_r;
  logic [QW:0]         ocnt_r;
  logic                pop;

  assign out_valid     = ocnt_r != '0;
  assign pop           = out_valid && out_ready;
  assign out_pixel_out = ofifo_r[rd_ptr_r].pixel;
  assign out_frame_end = ofifo_r[rd_ptr_r].frame_end;
  assign in_ready      = (ocnt_r + (QW+1)'(s1_valid_r)) < (QW+1)'(bstp_pkg::OFIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      ocnt_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QW'(1);
      end
      ocnt_r <= ocnt_r + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ofifo_r[wr_ptr_r] <= push_item;
    end
  end

  // Checks.
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= (QW+1)'(bstp_pkg::OFIFO_DEPTH))
    else $error("output queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && ocnt_r == (QW+1)'(bstp_pkg::OFIFO_DEPTH) |-> pop)
    else $error("output queue overflow");

  a_frame_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_item.frame_end |-> s1_ctrl_r.flush && s1_ctrl_r.last_col)
    else $error("frame end outside the last-row flush");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && r_eff == '0 && flush_pending_r && last_col |=> !flush_pending_r)
    else $error("flush pending not cleared after the last column");

  a_stage_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted transaction missing in the update stage");

endmodule
